// ===== src/bdq_pkg.sv =====
package bdq_pkg;

   localparam int DEPTH    = 64;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = IDX_W + 1;
   localparam int VALUE_W  = 31;
   localparam int KIND_W   = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 4'd0,
      KIND_PUSH_BACK  = 4'd1,
      KIND_POP_FRONT  = 4'd2,
      KIND_POP_BACK   = 4'd3,
      KIND_DELETE     = 4'd4,
      KIND_FIRST_N    = 4'd5,
      KIND_LAST_N     = 4'd6,
      KIND_ALL        = 4'd7,
      KIND_CLEAR      = 4'd8
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK_RD,
      ST_DEL_CMP,
      ST_DUMP_OUT,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic rd_en;
      logic del_step;
      logic load_status;
      logic load_dump;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     walk_empty;
      logic     data_last;
      logic     out_free;
   } sts_type;

   // ring slot of logical position pos, both below DEPTH
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== src/bdq_req_if.sv =====
interface bdq_req_if;
   logic                         valid;
   logic                         ready;
   logic [bdq_pkg::KIND_W-1:0]   kind;
   logic [bdq_pkg::VALUE_W-1:0]  operand;

   modport source (output valid, output kind, output operand, input ready);
   modport sink   (input valid, input kind, input operand, output ready);
endinterface

// ===== src/bdq_rsp_if.sv =====
interface bdq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bdq_pkg::VALUE_W-1:0]   element_value;
   logic                          has_value;
   logic [bdq_pkg::STATUS_W-1:0]  status;
   logic                          is_last;

   modport source (output valid, output element_value, output has_value, output status,
                   output is_last, input ready);
   modport sink   (input valid, input element_value, input has_value, input status,
                   input is_last, output ready);
endinterface

// ===== src/bdq_ram.sv =====
module bdq_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/bdq_ctrl.sv =====
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdq_pkg::sts_type  sts,
   output bdq_pkg::cmd_type  cmd
);
   bdq_pkg::state_type state_ff, state_in;
   logic               is_walk;
   logic               is_delete;

   assign is_delete = (sts.kind == bdq_pkg::KIND_DELETE);
   assign is_walk   = is_delete || (sts.kind == bdq_pkg::KIND_FIRST_N) ||
                      (sts.kind == bdq_pkg::KIND_LAST_N) || (sts.kind == bdq_pkg::KIND_ALL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = bdq_pkg::ST_EXEC;
         end
         bdq_pkg::ST_EXEC: begin
            if (is_walk && !sts.walk_empty) state_in = bdq_pkg::ST_WALK_RD;
            else                            state_in = bdq_pkg::ST_STATUS;
         end
         bdq_pkg::ST_WALK_RD: begin
            state_in = is_delete ? bdq_pkg::ST_DEL_CMP : bdq_pkg::ST_DUMP_OUT;
         end
         bdq_pkg::ST_DEL_CMP: begin
            if (sts.data_last) state_in = bdq_pkg::ST_STATUS;
         end
         bdq_pkg::ST_DUMP_OUT: begin
            if (sts.out_free && sts.data_last) state_in = bdq_pkg::ST_IDLE;
         end
         bdq_pkg::ST_STATUS: begin
            if (sts.out_free) state_in = bdq_pkg::ST_IDLE;
         end
         default: state_in = bdq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bdq_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         bdq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         bdq_pkg::ST_WALK_RD: begin
            cmd.rd_en = 1'b1;
         end
         bdq_pkg::ST_DEL_CMP: begin
            cmd.del_step = 1'b1;
            cmd.rd_en    = !sts.data_last;
         end
         bdq_pkg::ST_DUMP_OUT: begin
            // next read only once the current entry has left the read register
            cmd.load_dump = sts.out_free;
            cmd.rd_en     = sts.out_free && !sts.data_last;
         end
         bdq_pkg::ST_STATUS: begin
            cmd.load_status = sts.out_free;
         end
         default: ;
      endcase
   end
endmodule

// ===== src/bdq_datapath.sv =====
module bdq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bdq_pkg::cmd_type               cmd,
   output bdq_pkg::sts_type               sts,
   input  logic [bdq_pkg::KIND_W-1:0]     req_kind,
   input  logic [bdq_pkg::VALUE_W-1:0]    req_operand,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bdq_pkg::VALUE_W-1:0]    rsp_element_value,
   output logic                           rsp_has_value,
   output logic [bdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_is_last
);
   localparam int IDX_W   = bdq_pkg::IDX_W;
   localparam int CNT_W   = bdq_pkg::CNT_W;
   localparam int VALUE_W = bdq_pkg::VALUE_W;

   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   bdq_pkg::kind_type   kind_ff, kind_in;
   logic [VALUE_W-1:0]  operand_ff, operand_in;
   bdq_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]    wr_pos_ff, wr_pos_in;
   logic [CNT_W-1:0]    end_pos_ff, end_pos_in;
   logic                data_last_ff, data_last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_has_ff, rsp_has_in;
   bdq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   logic                full;
   logic                empty;
   logic                keep;
   logic                out_free;
   logic [IDX_W-1:0]    head_dec;
   logic [CNT_W-1:0]    walk_n;
   logic [CNT_W-1:0]    walk_start;

   bdq_ram #(.WIDTH(VALUE_W), .DEPTH(bdq_pkg::DEPTH)) u_bdq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full     = (count_ff == CNT_W'(bdq_pkg::DEPTH));
   assign empty    = (count_ff == '0);
   assign keep     = (rd_data != operand_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign head_dec = (head_ff == '0) ? IDX_W'(bdq_pkg::DEPTH - 1) : head_ff - 1'b1;
   assign rd_addr  = bdq_pkg::slot_of(head_ff, rd_pos_ff[IDX_W-1:0]);

   // number of entries to walk and the first position, saturated at the length
   always_comb begin
      if (kind_ff == bdq_pkg::KIND_DELETE || kind_ff == bdq_pkg::KIND_ALL) begin
         walk_n = count_ff;
      end else if (operand_ff < {{(VALUE_W-CNT_W){1'b0}}, count_ff}) begin
         walk_n = operand_ff[CNT_W-1:0];
      end else begin
         walk_n = count_ff;
      end
      walk_start = (kind_ff == bdq_pkg::KIND_LAST_N) ? count_ff - walk_n : '0;
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      operand_in    = operand_ff;
      status_in     = status_ff;
      rd_pos_in     = rd_pos_ff;
      wr_pos_in     = wr_pos_ff;
      end_pos_in    = end_pos_ff;
      data_last_in  = data_last_ff;
      wr_en         = 1'b0;
      wr_addr       = bdq_pkg::slot_of(head_ff, wr_pos_ff[IDX_W-1:0]);
      wr_data       = operand_ff;

      if (cmd.accept) begin
         kind_in    = bdq_pkg::kind_type'(req_kind);
         operand_in = req_operand;
      end

      if (cmd.exec) begin
         status_in  = bdq_pkg::STATUS_OK;
         rd_pos_in  = walk_start;
         wr_pos_in  = '0;
         end_pos_in = walk_start + walk_n - 1'b1;
         unique case (kind_ff)
            bdq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            bdq_pkg::KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = bdq_pkg::slot_of(head_ff, count_ff[IDX_W-1:0]);
                  count_in = count_ff + 1'b1;
               end
            end
            bdq_pkg::KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  head_in  = bdq_pkg::slot_of(head_ff, IDX_W'(1));
                  count_in = count_ff - 1'b1;
               end
            end
            bdq_pkg::KIND_POP_BACK: begin
               if (empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            bdq_pkg::KIND_CLEAR: begin
               count_in = '0;
               head_in  = '0;
            end
            default: ;
         endcase
      end

      if (cmd.rd_en) begin
         rd_pos_in    = rd_pos_ff + 1'b1;
         data_last_in = (rd_pos_ff == end_pos_ff);
      end

      // compaction: survivors move down to the write position, never past the read side
      if (cmd.del_step) begin
         if (keep) begin
            wr_en     = 1'b1;
            wr_data   = rd_data;
            wr_pos_in = wr_pos_ff + 1'b1;
         end
         if (data_last_ff) begin
            count_in = wr_pos_ff + CNT_W'(keep);
         end
      end
   end

   always_comb begin
      rsp_value_in  = rsp_value_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (cmd.load_dump) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rd_data;
         rsp_has_in    = 1'b1;
         rsp_status_in = bdq_pkg::STATUS_OK;
         rsp_last_in   = data_last_ff;
      end else if (cmd.load_status) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_has_in    = 1'b0;
         rsp_status_in = status_ff;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      operand_ff    <= operand_in;
      status_ff     <= status_in;
      rd_pos_ff     <= rd_pos_in;
      wr_pos_ff     <= wr_pos_in;
      end_pos_ff    <= end_pos_in;
      data_last_ff  <= data_last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign sts.kind       = kind_ff;
   assign sts.walk_empty = (walk_n == '0);
   assign sts.data_last  = data_last_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_has_value     = rsp_has_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_last       = rsp_last_ff;
endmodule

// ===== src/bounded_deque_with_value_delete.sv =====
// Channel   Dir  Fields                                        Transfer
// req_ch    in   kind[3:0], operand[30:0]                      valid & ready
// rsp_ch    out  element_value[30:0], has_value, status[1:0],  valid & ready
//                is_last
//
// One request at a time; req_ch.ready is high only while no request is in work.
// Push, pop, clear, unused kinds: the request executes, then a status result is loaded.
// Delete: one stored entry compared per cycle, then a status result.
// Dumps: one entry per cycle while rsp_ch.ready is held high; a stalled
// result holds its register and the walk waits. Reset: empty store, no clearing pass.
module bounded_deque_with_value_delete (
   input  logic       clock,
   input  logic       reset,
   bdq_req_if.sink    req_ch,
   bdq_rsp_if.source  rsp_ch
);
   bdq_pkg::cmd_type cmd;
   bdq_pkg::sts_type sts;

   bdq_ctrl u_bdq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdq_datapath u_bdq_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_ch.kind),
      .req_operand       (req_ch.operand),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_element_value (rsp_ch.element_value),
      .rsp_has_value     (rsp_ch.has_value),
      .rsp_status        (rsp_ch.status),
      .rsp_is_last       (rsp_ch.is_last)
   );
endmodule

// ===== src/bdq_checker.sv =====
module bdq_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bdq_pkg::VALUE_W-1:0]   element_value,
   input logic                          has_value,
   input logic [bdq_pkg::STATUS_W-1:0]  status,
   input logic                          is_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(element_value) &&
         $stable(has_value) && $stable(status) && $stable(is_last))
      else $error("result changed while stalled");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_dump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_value |-> status == bdq_pkg::STATUS_OK)
      else $error("dumped entry with non-ok status");

   a_status_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_value |-> element_value == '0 && is_last)
      else $error("status result not zero or not last");
endmodule

bind bounded_deque_with_value_delete bdq_port_checker u_bdq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .element_value (rsp_ch.element_value),
   .has_value     (rsp_ch.has_value),
   .status        (rsp_ch.status),
   .is_last       (rsp_ch.is_last)
);

// ===== sim/bdq_checker.sv =====
module bdq_checker
   import bdq_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   bdq_req_if    req_ch,
   bdq_rsp_if    rsp_ch,
   output int    error_count,
   output int    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [VALUE_W-1:0] element_value;
      logic               has_value;
      status_type         status;
      logic               is_last;
   } answer_type;

   answer_type         expected_answers[$];

   // shadow copy of the deque
   logic [VALUE_W-1:0] entries[DEPTH];
   logic [IDX_W-1:0]   front;
   logic [CNT_W-1:0]   fill;

   function automatic logic [IDX_W-1:0] ring_pos(input int pos);
      return IDX_W'((int'(front) + pos) % DEPTH);
   endfunction

   task automatic queue_answer(input logic [VALUE_W-1:0] value, input logic has,
                               input status_type st, input logic last);
      answer_type a;
      a.element_value = value;
      a.has_value     = has;
      a.status        = st;
      a.is_last       = last;
      expected_answers.push_back(a);
   endtask

   task automatic apply_to_store(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] op);
      status_type         st;
      int                 n;
      int                 start;
      int                 kept;
      logic [VALUE_W-1:0] v;
      st = STATUS_OK;
      case (k)
         KIND_PUSH_FRONT: begin
            if (fill == CNT_W'(DEPTH)) begin
               st = STATUS_FULL;
            end else begin
               front = ring_pos(DEPTH - 1);
               entries[front] = op;
               fill++;
            end
         end
         KIND_PUSH_BACK: begin
            if (fill == CNT_W'(DEPTH)) begin
               st = STATUS_FULL;
            end else begin
               entries[ring_pos(int'(fill))] = op;
               fill++;
            end
         end
         KIND_POP_FRONT: begin
            if (fill == '0) begin
               st = STATUS_EMPTY;
            end else begin
               front = ring_pos(1);
               fill--;
            end
         end
         KIND_POP_BACK: begin
            if (fill == '0) begin
               st = STATUS_EMPTY;
            end else begin
               fill--;
            end
         end
         KIND_DELETE: begin
            // compact survivors toward the front, order kept
            kept = 0;
            for (int i = 0; i < int'(fill); i++) begin
               v = entries[ring_pos(i)];
               if (v != op) begin
                  entries[ring_pos(kept)] = v;
                  kept++;
               end
            end
            fill = CNT_W'(kept);
         end
         KIND_FIRST_N, KIND_LAST_N, KIND_ALL: begin
            n = int'(fill);
            if (k != KIND_ALL && op < VALUE_W'(fill)) begin
               n = int'(op);
            end
            start = (k == KIND_LAST_N) ? int'(fill) - n : 0;
            if (n == 0) begin
               queue_answer('0, 1'b0, STATUS_OK, 1'b1);
            end
            for (int i = 0; i < n; i++) begin
               queue_answer(entries[ring_pos(start + i)], 1'b1, STATUS_OK, i == n - 1);
            end
            return;
         end
         KIND_CLEAR: begin
            fill  = '0;
            front = '0;
         end
         default: ;
      endcase
      queue_answer('0, 1'b0, st, 1'b1);
   endtask

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         fill        = '0;
         front       = '0;
         error_count = 0;
         expected_answers.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_to_store(req_ch.kind, req_ch.operand);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               $error("result transfer with nothing expected: element_value 0x%0h status %0d",
                      rsp_ch.element_value, rsp_ch.status);
               error_count++;
            end else begin
               a = expected_answers.pop_front();
               compare_field("element_value", 64'(a.element_value), 64'(rsp_ch.element_value));
               compare_field("has_value", 64'(a.has_value), 64'(rsp_ch.has_value));
               compare_field("status", 64'(a.status), 64'(rsp_ch.status));
               compare_field("is_last", 64'(a.is_last), 64'(rsp_ch.is_last));
            end
         end
      end
      pending_count = expected_answers.size();
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import bdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [VALUE_W-1:0] VALUE_MAX     = '1;
   localparam logic [KIND_W-1:0]  KIND_SPARE_LO = 4'd9;
   localparam logic [KIND_W-1:0]  KIND_SPARE_HI = 4'd15;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN       = DEPTH + 8;
   localparam int STALL_LIMIT = 4000;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   quiet_cycles;
   bit   long_hold_due;

   bdq_req_if req_ch ();
   bdq_rsp_if rsp_ch ();

   bounded_deque_with_value_delete dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bdq_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // small pool so deletes hit duplicates
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return VALUE_W'($urandom_range(0, 7));
      if (r < 78) return '0;
      if (r < 85) return VALUE_MAX;
      return VALUE_W'($urandom());
   endfunction

   function automatic logic [VALUE_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return VALUE_W'($urandom_range(0, 8));
      if (r < 85) return VALUE_W'($urandom_range(0, DEPTH + 2));
      return VALUE_W'($urandom());
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return KIND_PUSH_FRONT;
      if (r < 40) return KIND_PUSH_BACK;
      if (r < 50) return KIND_POP_FRONT;
      if (r < 60) return KIND_POP_BACK;
      if (r < 70) return KIND_DELETE;
      if (r < 78) return KIND_FIRST_N;
      if (r < 86) return KIND_LAST_N;
      if (r < 93) return KIND_ALL;
      if (r < 96) return KIND_CLEAR;
      return KIND_W'($urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI)));
   endfunction

   task automatic offer_request(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] op);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= k;
      req_ch.operand <= op;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic offer_random_request();
      logic [KIND_W-1:0] k;
      k = pick_kind();
      if (k == KIND_FIRST_N || k == KIND_LAST_N) begin
         offer_request(k, pick_count());
      end else begin
         offer_request(k, pick_value());
      end
   endtask

   // result side: random ready pattern plus one long hold-off on request
   initial begin
      int run;
      int gap;
      bit hold_done;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         if (long_hold_due && !hold_done) begin
            hold_done = 1'b1;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b0;
            end
         end
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
         repeat (run) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      long_hold_due  = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.kind    = '0;
      req_ch.operand = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-store corners, extremes, saturation, sole-element cases
      offer_request(KIND_POP_FRONT, '0);
      offer_request(KIND_POP_BACK, VALUE_MAX);
      offer_request(KIND_ALL, '0);
      offer_request(KIND_LAST_N, VALUE_W'(3));
      offer_request(KIND_DELETE, '0);
      offer_request(KIND_PUSH_BACK, VALUE_MAX);
      offer_request(KIND_PUSH_FRONT, '0);
      offer_request(KIND_PUSH_BACK, 31'h5555_5555);
      offer_request(KIND_PUSH_FRONT, 31'h2aaa_aaaa);
      offer_request(KIND_PUSH_BACK, 31'h5555_5555);
      offer_request(KIND_FIRST_N, VALUE_W'(2));
      offer_request(KIND_LAST_N, VALUE_MAX);
      offer_request(KIND_FIRST_N, '0);
      offer_request(KIND_DELETE, 31'h5555_5555);
      offer_request(KIND_DELETE, VALUE_W'(123));
      offer_request(KIND_ALL, '0);
      offer_request(KIND_POP_FRONT, '0);
      offer_request(KIND_POP_BACK, '0);
      offer_request(KIND_POP_FRONT, '0);
      offer_request(KIND_POP_BACK, '0);
      offer_request(KIND_PUSH_FRONT, VALUE_W'(7));
      offer_request(KIND_DELETE, VALUE_W'(7));
      offer_request(KIND_PUSH_BACK, VALUE_W'(9));
      offer_request(KIND_SPARE_LO, VALUE_MAX);
      offer_request(KIND_SPARE_HI, '0);
      offer_request(KIND_CLEAR, '0);

      // fill to the brim while the result side holds off
      long_hold_due = 1'b1;
      repeat (DEPTH) begin
         offer_request($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value());
      end
      offer_request(KIND_PUSH_FRONT, pick_value());
      offer_request(KIND_PUSH_BACK, pick_value());
      offer_request(KIND_ALL, '0);
      offer_request(KIND_DELETE, VALUE_W'($urandom_range(0, 7)));

      repeat (16) offer_random_request();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
